/* design/tmsg_pkg.sv */
// Shared types and constants for the text-mode scan line generator.
// No dependencies; every module of the block imports this package.
package tmsg_pkg;

	localparam int MAX_CELLS  = 16384;
	localparam int LINE_BYTES = 160;
	localparam int FONT_CHARS = 128;
	localparam int GLYPH_ROWS = 8;
	localparam int WORD_BYTES = 8;
	localparam int WORD_LIMIT = 20;

	localparam int CELL_AW  = $clog2(MAX_CELLS);
	localparam int FONT_AW  = $clog2(FONT_CHARS * GLYPH_ROWS);
	localparam int BYTE_AW  = $clog2(LINE_BYTES);
	localparam int LANE_W   = $clog2(WORD_BYTES);
	localparam int GROW_W   = $clog2(GLYPH_ROWS);
	localparam int WORD_CAP = (LINE_BYTES / WORD_BYTES < WORD_LIMIT) ?
		LINE_BYTES / WORD_BYTES : WORD_LIMIT;
	localparam int WORD_AW  = $clog2(WORD_CAP + 1);

	localparam int KIND_W = 2;
	localparam int ADDR_W = 14;
	localparam int DATA_W = 8;
	localparam int PIX_W  = 64;
	localparam int LINE_W = 10;
	localparam int FH_W   = 10;
	localparam int FW_W   = 11;
	localparam int ROWS_W = 8;
	localparam int COLS_W = 8;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 11;

	localparam int IQ_DEPTH = 4;
	localparam int OQ_DEPTH = 8;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	localparam logic [DATA_W-1:0] CODE_LO = DATA_W'(32);
	localparam logic [DATA_W-1:0] CODE_HI = DATA_W'(127);

	localparam logic [KIND_W-1:0] KIND_TICK = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_CELL = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_FONT = KIND_W'(2);

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLS    = CFG_IDX_W'(3);

	localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = FH_W'(480);
	localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = FW_W'(640);
	localparam logic [ROWS_W-1:0] RST_TEXT_ROWS    = ROWS_W'(60);
	localparam logic [COLS_W-1:0] RST_TEXT_COLS    = COLS_W'(80);

	typedef enum logic [1:0] {
		OP_TICK,
		OP_CELL,
		OP_FONT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [FH_W-1:0]   frame_height;
		logic [FW_W-1:0]   frame_width;
		logic [ROWS_W-1:0] text_rows;
		logic [COLS_W-1:0] text_cols;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel_word;
		logic [LINE_W-1:0] line_number;
		logic              last;
	} res_t;

endpackage

/* design/tmsg_front.sv */
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on tmsg_pkg.
module tmsg_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [tmsg_pkg::KIND_W-1:0] kind,
	input  logic [tmsg_pkg::ADDR_W-1:0] address,
	input  logic [tmsg_pkg::DATA_W-1:0] data,
	input  logic                    busy,
	output logic                    cmd_valid,
	output tmsg_pkg::cmd_t          cmd,
	input  logic                    cmd_pop
);
	import tmsg_pkg::*;

	cmd_t             q_mem [IQ_DEPTH];
	logic [IQ_AW-1:0] wr_ptr_q;
	logic [IQ_AW-1:0] rd_ptr_q;
	logic [IQ_CW-1:0] cnt_q;
	logic             keep;
	logic             enq;
	cmd_t             new_cmd;

	always_comb begin
		keep        = 1'b0;
		new_cmd.op  = OP_TICK;
		new_cmd.addr = address;
		new_cmd.data = data;
		unique case (kind)
			KIND_TICK: begin
				keep       = 1'b1;
				new_cmd.op = OP_TICK;
			end
			KIND_CELL: begin
				keep       = 32'(address) < 32'(MAX_CELLS);
				new_cmd.op = OP_CELL;
			end
			KIND_FONT: begin
				keep       = 32'(address) < 32'(FONT_CHARS * GLYPH_ROWS);
				new_cmd.op = OP_FONT;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full      = (cnt_q == IQ_CW'(IQ_DEPTH)) || busy;
	assign enq       = push && !full && keep;
	assign cmd_valid = cnt_q != '0;
	assign cmd       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!enq && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* design/tmsg_back.sv */
// Back end: screen and font stores, clearing pass and scan line builder.
// Depends on tmsg_pkg; feeds the result queue under a slot credit.
module tmsg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tmsg_pkg::cfg_t              cfg,
	input  logic                        cmd_valid,
	input  tmsg_pkg::cmd_t              cmd,
	output logic                        cmd_pop,
	output logic                        clearing,
	input  logic [tmsg_pkg::OQ_CW-1:0]  oq_cnt,
	output logic                        res_push,
	output tmsg_pkg::res_t              res
);
	import tmsg_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ORG,
		S_REL,
		S_BASE,
		S_RUN
	} state_t;

	localparam int ORGB_W = FW_W - 4;
	localparam int EXT_W  = FW_W + 1;

	state_t               state_q;
	logic [CELL_AW-1:0]   clr_q;
	logic [LINE_W-1:0]    line_q;
	logic [LINE_W-1:0]    y_q;
	logic [FH_W-1:0]      org_y_q;
	logic [ORGB_W-1:0]    org_b_q;
	logic [FW_W-1:0]      tall_q;
	logic [WORD_AW-1:0]   words_q;
	logic                 in_area_q;
	logic [LINE_W-1:0]    rel_q;
	logic [CELL_AW-1:0]   row_base_q;
	logic [BYTE_AW-1:0]   b_q;
	logic [WORD_AW-1:0]   w_q;
	logic [OQ_CW-1:0]     inflight_q;

	logic [DATA_W-1:0]    scr_mem  [MAX_CELLS];
	logic [DATA_W-1:0]    font_mem [FONT_CHARS * GLYPH_ROWS];

	logic                 scr_we;
	logic [CELL_AW-1:0]   scr_wa;
	logic [DATA_W-1:0]    scr_wd;
	logic                 font_we;
	logic [CELL_AW-1:0]   cell_addr;
	logic [FONT_AW-1:0]   font_addr;

	logic [FW_W-1:0]      tall;
	logic [FW_W-1:0]      wide;
	logic [FH_W-1:0]      org_y;
	logic [FW_W-1:0]      org_x;
	logic [FW_W:0]        words_sum;
	logic [FW_W-6:0]      words_raw;
	logic [WORD_AW-1:0]   words;
	logic [LINE_W:0]      next_line;
	logic [EXT_W:0]       area_end;

	logic [EXT_W-1:0]     b_ext;
	logic [EXT_W-1:0]     org_ext;
	logic [EXT_W-1:0]     col_ext;
	logic                 vis;
	logic                 word_start;
	logic                 word_end;
	logic                 word_last;
	logic                 space;
	logic                 issue;

	logic                 v_s1;
	logic                 end_s1;
	logic                 last_s1;
	logic                 vis_s1;
	logic [LINE_W-1:0]    y_s1;
	logic [GROW_W-1:0]    grow_s1;
	logic [DATA_W-1:0]    scr_rd_s1;
	logic                 code_ok;

	logic                 v_s2;
	logic                 end_s2;
	logic                 last_s2;
	logic                 vis_s2;
	logic [LINE_W-1:0]    y_s2;
	logic [DATA_W-1:0]    font_rd_s2;
	logic [DATA_W-1:0]    byte_s2;
	logic [PIX_W-1:0]     word_q;
	logic [PIX_W-1:0]     word_next;

	// Line setup arithmetic
	always_comb begin
		tall      = {cfg.text_rows, 3'b000};
		wide      = {cfg.text_cols, 3'b000};
		org_y     = (FW_W'(cfg.frame_height) >= tall) ?
			FH_W'((FW_W'(cfg.frame_height) - tall) >> 1) : '0;
		org_x     = (cfg.frame_width >= wide) ? ((cfg.frame_width - wide) >> 1) : '0;
		words_sum = (FW_W + 1)'(cfg.frame_width) + (FW_W + 1)'(63);
		words_raw = words_sum[FW_W:6];
		words     = (32'(words_raw) > 32'(WORD_CAP)) ? WORD_AW'(WORD_CAP) :
			WORD_AW'(words_raw);
		next_line = (LINE_W + 1)'(y_q) + 1'b1;
		area_end  = (EXT_W + 1)'(org_y_q) + (EXT_W + 1)'(tall_q);
	end

	// Byte issue
	always_comb begin
		b_ext      = EXT_W'(b_q);
		org_ext    = EXT_W'(org_b_q);
		col_ext    = b_ext - org_ext;
		vis        = in_area_q && (b_ext >= org_ext) &&
			(col_ext < EXT_W'(cfg.text_cols)) &&
			(EXT_W'({b_q, 3'b000}) < EXT_W'(cfg.frame_width));
		cell_addr  = row_base_q + CELL_AW'(col_ext);
		word_start = b_q[LANE_W-1:0] == '0;
		word_end   = b_q[LANE_W-1:0] == '1;
		word_last  = w_q == (words_q - 1'b1);
		space      = ((OQ_CW + 1)'(oq_cnt) + (OQ_CW + 1)'(inflight_q)) <
			(OQ_CW + 1)'(OQ_DEPTH);
		issue      = (state_q == S_RUN) && (!word_start || space);
	end

	assign clearing = state_q == S_CLEAR;
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign scr_we   = clearing || (cmd_pop && cmd.op == OP_CELL);
	assign scr_wa   = clearing ? clr_q : cmd.addr[CELL_AW-1:0];
	assign scr_wd   = clearing ? '0 : cmd.data;
	assign font_we  = cmd_pop && cmd.op == OP_FONT;

	always_ff @(posedge clk) begin
		if (scr_we) begin
			scr_mem[scr_wa] <= scr_wd;
		end
		scr_rd_s1 <= scr_mem[cell_addr];
	end

	always_ff @(posedge clk) begin
		if (font_we) begin
			font_mem[cmd.addr[FONT_AW-1:0]] <= cmd.data;
		end
		font_rd_s2 <= font_mem[font_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			line_q     <= '0;
			y_q        <= '0;
			org_y_q    <= '0;
			org_b_q    <= '0;
			tall_q     <= '0;
			words_q    <= '0;
			in_area_q  <= 1'b0;
			rel_q      <= '0;
			row_base_q <= '0;
			b_q        <= '0;
			w_q        <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == MAX_CELLS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid && cmd.op == OP_TICK) begin
						y_q     <= line_q;
						state_q <= S_ORG;
					end
				end
				S_ORG: begin
					org_y_q <= org_y;
					org_b_q <= org_x[FW_W-2:3];
					tall_q  <= tall;
					words_q <= words;
					state_q <= S_REL;
				end
				S_REL: begin
					in_area_q <= (y_q >= org_y_q) && ((EXT_W + 1)'(y_q) < area_end);
					rel_q     <= y_q - org_y_q;
					state_q   <= S_BASE;
				end
				S_BASE: begin
					row_base_q <= CELL_AW'(rel_q[LINE_W-1:GROW_W] * cfg.text_cols);
					line_q     <= (next_line >= (LINE_W + 1)'(cfg.frame_height)) ?
						'0 : next_line[LINE_W-1:0];
					b_q        <= '0;
					w_q        <= '0;
					state_q    <= (words_q == '0) ? S_IDLE : S_RUN;
				end
				S_RUN: begin
					if (issue) begin
						b_q <= b_q + 1'b1;
						if (word_end) begin
							w_q <= w_q + 1'b1;
							if (word_last) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Read pipeline: screen store, then font store, then word assembly
	always_comb begin
		code_ok   = (scr_rd_s1 >= CODE_LO) && (scr_rd_s1 <= CODE_HI);
		font_addr = FONT_AW'({scr_rd_s1, grow_s1});
		byte_s2   = vis_s2 ? font_rd_s2 : '0;
		word_next = {byte_s2, word_q[PIX_W-1:DATA_W]};
	end

	assign res_push        = v_s2 && end_s2;
	assign res.pixel_word  = word_next;
	assign res.line_number = y_s2;
	assign res.last        = last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			inflight_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue && word_start && !res_push) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (!(issue && word_start) && res_push) begin
				inflight_q <= inflight_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		end_s1  <= word_end;
		last_s1 <= word_end && word_last;
		vis_s1  <= vis;
		y_s1    <= y_q;
		grow_s1 <= rel_q[GROW_W-1:0];
		end_s2  <= end_s1;
		last_s2 <= last_s1;
		vis_s2  <= vis_s1 && code_ok;
		y_s2    <= y_s1;
		if (v_s2) begin
			word_q <= word_next;
		end
	end

endmodule

/* design/tmsg_outq.sv */
// Result queue: holds finished pixel words until popped.
// Depends on tmsg_pkg.
module tmsg_outq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       res_push,
	input  tmsg_pkg::res_t             res,
	input  logic                       pop,
	output logic                       empty,
	output tmsg_pkg::res_t             head,
	output logic [tmsg_pkg::OQ_CW-1:0] cnt
);
	import tmsg_pkg::*;

	res_t             q_mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             deq;

	assign empty = cnt_q == '0;
	assign deq   = pop && !empty;
	assign head  = q_mem[rd_ptr_q];
	assign cnt   = cnt_q;

	always_ff @(posedge clk) begin
		if (res_push) begin
			q_mem[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (res_push && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!res_push && deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* design/text_mode_scanline_generator_core.sv */
// Flow: a write is queued, then stored when the back end pops it in S_IDLE. A line tick
// passes through S_ORG, S_REL and S_BASE; S_RUN then issues one line byte per cycle,
// while the result queue has a free slot for each new word, via the single read port
// of the screen store, the font store read and word assembly (at most 20 words a line).
// Reset: queues empty, registers at their defaults, line counter 0; a clearing pass over
// all 16384 cells zeroes the screen store, with full held high until it ends.
module text_mode_scanline_generator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [tmsg_pkg::KIND_W-1:0]       kind,
	input  logic [tmsg_pkg::ADDR_W-1:0]       address,
	input  logic [tmsg_pkg::DATA_W-1:0]       data,
	output logic                              empty,
	input  logic                              pop,
	output logic [tmsg_pkg::PIX_W-1:0]        pixel_word,
	output logic [tmsg_pkg::LINE_W-1:0]       line_number,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tmsg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmsg_pkg::CFG_DW-1:0]       cfg_data
);
	import tmsg_pkg::*;

	cfg_t             cfg_q;
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_pop;
	logic             clearing;
	logic [OQ_CW-1:0] oq_cnt;
	logic             res_push;
	res_t             res;
	res_t             head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_height <= RST_FRAME_HEIGHT;
			cfg_q.frame_width  <= RST_FRAME_WIDTH;
			cfg_q.text_rows    <= RST_TEXT_ROWS;
			cfg_q.text_cols    <= RST_TEXT_COLS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FH_W-1:0];
				CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[FW_W-1:0];
				CFG_TEXT_ROWS:    cfg_q.text_rows    <= cfg_data[ROWS_W-1:0];
				CFG_TEXT_COLS:    cfg_q.text_cols    <= cfg_data[COLS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tmsg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.address   (address),
		.data      (data),
		.busy      (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tmsg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.oq_cnt    (oq_cnt),
		.res_push  (res_push),
		.res       (res)
	);

	tmsg_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.pop      (pop),
		.empty    (empty),
		.head     (head),
		.cnt      (oq_cnt)
	);

	assign pixel_word  = head.pixel_word;
	assign line_number = head.line_number;
	assign last        = head.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (oq_cnt != OQ_CW'(OQ_DEPTH)))
		else $error("result pushed into a full queue");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("input open during clearing pass");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

endmodule
